[hw/rtl/ieval_pkg.sv]
`timescale 1ns / 1ps

package ieval_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int OPC_W           = 3;

    localparam logic [OPC_W-1:0] OPC_ADD  = 3'd1;
    localparam logic [OPC_W-1:0] OPC_SUB  = 3'd2;
    localparam logic [OPC_W-1:0] OPC_MUL  = 3'd3;
    localparam logic [OPC_W-1:0] OPC_DIV  = 3'd4;
    localparam logic [OPC_W-1:0] OPC_LPAR = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FEED,
        S_DISPATCH,
        S_PEEK,
        S_PEEKW,
        S_RB,
        S_RA,
        S_EXEC,
        S_DIVW,
        S_LOOPEND,
        S_LASTCHK,
        S_FIN1,
        S_RD0,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        M_OP,
        M_RPAR,
        M_FIN
    } mode_t;

    function automatic logic [1:0] prio(input logic [OPC_W-1:0] code);
        logic [1:0] p;
        p = 2'd0;
        if (code inside {OPC_ADD, OPC_SUB})
        begin
            p = 2'd1;
        end
        else if (code inside {OPC_MUL, OPC_DIV})
        begin
            p = 2'd2;
        end
        return p;
    endfunction

endpackage

[hw/rtl/ieval_div.sv]
`timescale 1ns / 1ps

module ieval_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 32'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

[hw/rtl/infix_expression_evaluator_unit.sv]
`timescale 1ns / 1ps

// Evaluates an integer infix expression fed one ASCII character per word, with
// the final character marked by last_char; one result word (value, status) is
// given per expression. The block takes one character at a time and drops
// ready while it works: an operator or ')' first reduces the stacks as far as
// precedence and brackets allow, and a division waits on the bit-serial
// divider. The end of an expression reduces what is left on the stacks. Each
// stack is a memory with one registered read port, so each reduction reads its
// two operands one after the other. The result waits in an output register
// while the next expression is taken.

module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = ieval_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         character,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    ieval_pkg::state_t state_reg, state_next;
    ieval_pkg::mode_t  mode_reg, mode_next;

    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic [2:0]  code_reg, code_next;
    logic [2:0]  top_reg, top_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] acc_reg, acc_next;
    logic        in_num_reg, in_num_next;
    logic        have_reg, have_next;
    logic [1:0]  err_reg, err_next;
    logic [CW-1:0] opnd_cnt_reg, opnd_cnt_next;
    logic [CW-1:0] oper_cnt_reg, oper_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg, value_next;
    logic [1:0]  status_reg, status_next;

    logic        set_err;
    logic [1:0]  err_code;

    logic [31:0] opnd_mem [STACK_DEPTH];
    logic [2:0]  oper_mem [STACK_DEPTH];
    logic        opnd_we, oper_we;
    logic [AW-1:0] opnd_waddr, opnd_raddr, oper_waddr, oper_raddr;
    logic [31:0] opnd_wdata, opnd_rdata;
    logic [2:0]  oper_wdata, oper_rdata;

    logic        div_start, div_done;
    logic [31:0] div_q;

    logic [CW-1:0] opnd_m1, opnd_m2, oper_m1;
    logic        is_digit, is_op, err_ok, opnd_full, oper_full, red_go, fin_lpar;
    logic [2:0]  char_code;
    logic [7:0]  digit;
    logic [31:0] alu_r;

    assign opnd_m1   = opnd_cnt_reg - CW'(1);
    assign opnd_m2   = opnd_cnt_reg - CW'(2);
    assign oper_m1   = oper_cnt_reg - CW'(1);
    assign opnd_full = opnd_cnt_reg >= CW'(STACK_DEPTH);
    assign oper_full = oper_cnt_reg >= CW'(STACK_DEPTH);
    assign err_ok    = err_reg == ieval_pkg::ST_OK;
    assign is_digit  = (char_reg >= ieval_pkg::CH_0) && (char_reg <= ieval_pkg::CH_9);
    assign digit     = char_reg - ieval_pkg::CH_0;

    always_comb
    begin
        case (char_reg)
            ieval_pkg::CH_PLUS:  char_code = ieval_pkg::OPC_ADD;
            ieval_pkg::CH_MINUS: char_code = ieval_pkg::OPC_SUB;
            ieval_pkg::CH_STAR:  char_code = ieval_pkg::OPC_MUL;
            ieval_pkg::CH_SLASH: char_code = ieval_pkg::OPC_DIV;
            default:             char_code = 3'd0;
        endcase
    end
    assign is_op = char_code != 3'd0;

    assign fin_lpar = (mode_reg == ieval_pkg::M_FIN) && (oper_rdata == ieval_pkg::OPC_LPAR);
    assign red_go   = (oper_rdata != ieval_pkg::OPC_LPAR) &&
                      ((mode_reg != ieval_pkg::M_OP) ||
                       (ieval_pkg::prio(oper_rdata) >= ieval_pkg::prio(code_reg)));

    always_comb
    begin
        case (top_reg)
            ieval_pkg::OPC_ADD: alu_r = opnd_rdata + b_reg;
            ieval_pkg::OPC_SUB: alu_r = opnd_rdata - b_reg;
            default:            alu_r = opnd_rdata * b_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ieval_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = ieval_pkg::S_FEED;
                end
            ieval_pkg::S_FEED:
                if (!err_ok || is_digit)
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
                else
                begin
                    state_next = ieval_pkg::S_DISPATCH;
                end
            ieval_pkg::S_DISPATCH:
                if (!err_ok || char_reg == ieval_pkg::CH_LPAR)
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
                else if ((char_reg == ieval_pkg::CH_RPAR || is_op) && have_reg)
                begin
                    state_next = ieval_pkg::S_PEEK;
                end
                else
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
            ieval_pkg::S_PEEK:
                if (oper_cnt_reg == CW'(0))
                begin
                    state_next = ieval_pkg::S_LOOPEND;
                end
                else
                begin
                    state_next = ieval_pkg::S_PEEKW;
                end
            ieval_pkg::S_PEEKW:
                if (fin_lpar)
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
                else if (red_go)
                begin
                    state_next = (opnd_cnt_reg < CW'(2)) ? ieval_pkg::S_LASTCHK
                                                         : ieval_pkg::S_RB;
                end
                else
                begin
                    state_next = ieval_pkg::S_LOOPEND;
                end
            ieval_pkg::S_RB:
                state_next = ieval_pkg::S_RA;
            ieval_pkg::S_RA:
                state_next = ieval_pkg::S_EXEC;
            ieval_pkg::S_EXEC:
                if (top_reg == ieval_pkg::OPC_DIV)
                begin
                    state_next = (b_reg == 32'd0) ? ieval_pkg::S_LASTCHK : ieval_pkg::S_DIVW;
                end
                else if (top_reg == ieval_pkg::OPC_LPAR || top_reg == 3'd0 ||
                         top_reg > ieval_pkg::OPC_LPAR)
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
                else
                begin
                    state_next = ieval_pkg::S_PEEK;
                end
            ieval_pkg::S_DIVW:
                if (div_done)
                begin
                    state_next = ieval_pkg::S_PEEK;
                end
            ieval_pkg::S_LOOPEND:
                if (mode_reg == ieval_pkg::M_FIN && opnd_cnt_reg == CW'(1))
                begin
                    state_next = ieval_pkg::S_RD0;
                end
                else
                begin
                    state_next = ieval_pkg::S_LASTCHK;
                end
            ieval_pkg::S_LASTCHK:
                if (!last_reg)
                begin
                    state_next = ieval_pkg::S_IDLE;
                end
                else if (!err_ok)
                begin
                    state_next = ieval_pkg::S_OUT;
                end
                else
                begin
                    state_next = ieval_pkg::S_FIN1;
                end
            ieval_pkg::S_FIN1:
                if (!err_ok || !have_reg)
                begin
                    state_next = ieval_pkg::S_OUT;
                end
                else
                begin
                    state_next = ieval_pkg::S_PEEK;
                end
            ieval_pkg::S_RD0:
                state_next = ieval_pkg::S_OUT;
            ieval_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ieval_pkg::S_IDLE;
                end
            default:
                state_next = ieval_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next      = mode_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        code_next      = code_reg;
        top_next       = top_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        in_num_next    = in_num_reg;
        have_next      = have_reg;
        opnd_cnt_next  = opnd_cnt_reg;
        oper_cnt_next  = oper_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        set_err        = 1'b0;
        err_code       = ieval_pkg::ST_OK;
        opnd_we        = 1'b0;
        opnd_waddr     = opnd_cnt_reg[AW-1:0];
        opnd_wdata     = acc_reg;
        opnd_raddr     = '0;
        oper_we        = 1'b0;
        oper_waddr     = oper_cnt_reg[AW-1:0];
        oper_wdata     = ieval_pkg::OPC_LPAR;
        oper_raddr     = oper_m1[AW-1:0];
        div_start      = 1'b0;
        in_ready       = state_reg == ieval_pkg::S_IDLE;
        case (state_reg)
            ieval_pkg::S_IDLE:
                if (in_valid)
                begin
                    char_next = character;
                    last_next = last_char;
                end
            ieval_pkg::S_FEED:
                if (err_ok)
                begin
                    if (is_digit)
                    begin
                        if (have_reg && !in_num_reg)
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_BAD;
                        end
                        else
                        begin
                            acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} +
                                       {24'd0, digit};
                            in_num_next = 1'b1;
                            have_next   = 1'b1;
                        end
                    end
                    else if (in_num_reg)
                    begin
                        in_num_next = 1'b0;
                        if (opnd_full)
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_OVF;
                        end
                        else
                        begin
                            opnd_we       = 1'b1;
                            opnd_cnt_next = opnd_cnt_reg + CW'(1);
                            acc_next      = 32'd0;
                        end
                    end
                end
            ieval_pkg::S_DISPATCH:
                if (err_ok)
                begin
                    if (char_reg == ieval_pkg::CH_LPAR)
                    begin
                        if (have_reg)
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_BAD;
                        end
                        else if (oper_full)
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_OVF;
                        end
                        else
                        begin
                            oper_we       = 1'b1;
                            oper_cnt_next = oper_cnt_reg + CW'(1);
                        end
                    end
                    else if ((char_reg == ieval_pkg::CH_RPAR || is_op) && have_reg)
                    begin
                        mode_next = (char_reg == ieval_pkg::CH_RPAR) ? ieval_pkg::M_RPAR
                                                                     : ieval_pkg::M_OP;
                        code_next = char_code;
                    end
                    else
                    begin
                        set_err  = 1'b1;
                        err_code = ieval_pkg::ST_BAD;
                    end
                end
            ieval_pkg::S_PEEKW:
            begin
                top_next = oper_rdata;
                if (fin_lpar || (red_go && opnd_cnt_reg < CW'(2)))
                begin
                    set_err  = 1'b1;
                    err_code = ieval_pkg::ST_BAD;
                end
            end
            ieval_pkg::S_RB:
                opnd_raddr = opnd_m1[AW-1:0];
            ieval_pkg::S_RA:
            begin
                b_next     = opnd_rdata;
                opnd_raddr = opnd_m2[AW-1:0];
            end
            ieval_pkg::S_EXEC:
                if (top_reg == ieval_pkg::OPC_DIV)
                begin
                    if (b_reg == 32'd0)
                    begin
                        set_err  = 1'b1;
                        err_code = ieval_pkg::ST_DIV0;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else if (top_reg == ieval_pkg::OPC_LPAR || top_reg == 3'd0 ||
                         top_reg > ieval_pkg::OPC_LPAR)
                begin
                    set_err  = 1'b1;
                    err_code = ieval_pkg::ST_BAD;
                end
                else
                begin
                    opnd_we       = 1'b1;
                    opnd_waddr    = opnd_m2[AW-1:0];
                    opnd_wdata    = alu_r;
                    opnd_cnt_next = opnd_m1;
                    oper_cnt_next = oper_m1;
                end
            ieval_pkg::S_DIVW:
                if (div_done)
                begin
                    opnd_we       = 1'b1;
                    opnd_waddr    = opnd_m2[AW-1:0];
                    opnd_wdata    = div_q;
                    opnd_cnt_next = opnd_m1;
                    oper_cnt_next = oper_m1;
                end
            ieval_pkg::S_LOOPEND:
                case (mode_reg)
                    ieval_pkg::M_RPAR:
                        if (oper_cnt_reg == CW'(0))
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_BAD;
                        end
                        else
                        begin
                            oper_cnt_next = oper_m1;
                        end
                    ieval_pkg::M_OP:
                        if (oper_full)
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_OVF;
                        end
                        else
                        begin
                            oper_we       = 1'b1;
                            oper_wdata    = code_reg;
                            oper_cnt_next = oper_cnt_reg + CW'(1);
                            have_next     = 1'b0;
                        end
                    default:
                        if (opnd_cnt_reg != CW'(1))
                        begin
                            set_err  = 1'b1;
                            err_code = ieval_pkg::ST_BAD;
                        end
                endcase
            ieval_pkg::S_LASTCHK:
                if (last_reg && err_ok && in_num_reg)
                begin
                    in_num_next = 1'b0;
                    if (opnd_full)
                    begin
                        set_err  = 1'b1;
                        err_code = ieval_pkg::ST_OVF;
                    end
                    else
                    begin
                        opnd_we       = 1'b1;
                        opnd_cnt_next = opnd_cnt_reg + CW'(1);
                        acc_next      = 32'd0;
                    end
                end
            ieval_pkg::S_FIN1:
                if (err_ok)
                begin
                    mode_next = ieval_pkg::M_FIN;
                    if (!have_reg)
                    begin
                        set_err  = 1'b1;
                        err_code = ieval_pkg::ST_BAD;
                    end
                end
            ieval_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = err_ok ? opnd_rdata : 32'd0;
                    status_next    = err_reg;
                    opnd_cnt_next  = '0;
                    oper_cnt_next  = '0;
                    acc_next       = 32'd0;
                    in_num_next    = 1'b0;
                    have_next      = 1'b0;
                    set_err        = 1'b1;
                    err_code       = ieval_pkg::ST_OK;
                end
            default:
            begin
            end
        endcase
        if (state_reg == ieval_pkg::S_OUT && set_err)
        begin
            err_next = ieval_pkg::ST_OK;
        end
        else if (set_err && err_ok)
        begin
            err_next = err_code;
        end
        else
        begin
            err_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ieval_pkg::S_IDLE;
            mode_reg      <= ieval_pkg::M_OP;
            acc_reg       <= 32'd0;
            in_num_reg    <= 1'b0;
            have_reg      <= 1'b0;
            err_reg       <= ieval_pkg::ST_OK;
            opnd_cnt_reg  <= '0;
            oper_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            have_reg      <= have_next;
            err_reg       <= err_next;
            opnd_cnt_reg  <= opnd_cnt_next;
            oper_cnt_reg  <= oper_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        code_reg   <= code_next;
        top_reg    <= top_next;
        b_reg      <= b_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // operand stack
    always_ff @(posedge clk)
    begin
        if (opnd_we)
        begin
            opnd_mem[opnd_waddr] <= opnd_wdata;
        end
        opnd_rdata <= opnd_mem[opnd_raddr];
    end

    // operator stack
    always_ff @(posedge clk)
    begin
        if (oper_we)
        begin
            oper_mem[oper_waddr] <= oper_wdata;
        end
        oper_rdata <= oper_mem[oper_raddr];
    end

    ieval_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opnd_rdata),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_opnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        opnd_cnt_reg <= CW'(STACK_DEPTH))
        else $error("operand count beyond depth");

    a_oper_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oper_cnt_reg <= CW'(STACK_DEPTH))
        else $error("operator count beyond depth");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ieval_pkg::S_DIVW)
        else $error("divider done outside wait");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && status_reg != ieval_pkg::ST_OK |-> value_reg == 32'd0)
        else $error("nonzero value with error status");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ieval_pkg::S_OUT && state_next == ieval_pkg::S_IDLE
        |=> opnd_cnt_reg == '0 && oper_cnt_reg == '0 && err_reg == ieval_pkg::ST_OK)
        else $error("expression state not cleared");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = ieval_pkg::STACK_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] val;
        logic [1:0]  st;
    } res_t;

    typedef struct {
        logic [7:0]  ch;
        logic        lst;
        logic        chk;
        logic [31:0] val;
        logic [1:0]  st;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  character;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] value;
    logic [1:0]  status;

    infix_expression_evaluator_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .character(character), .last_char(last_char), .out_valid(out_valid),
        .out_ready(out_ready), .value(value), .status(status)
    );

    // evaluator state
    logic [31:0] opnd [DEPTH];
    logic [2:0]  oper [DEPTH];
    int          n_opnd, n_oper;
    logic [31:0] acc;
    bit          in_num, have_val;
    logic [1:0]  err;

    res_t        pending_q[$];
    row_t        dir_q[$];
    int          errors, words_in, results_seen, long_hold;
    int          st_hits[4];
    bit          stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int op_rank(logic [2:0] c);
        if (c == ieval_pkg::OPC_ADD || c == ieval_pkg::OPC_SUB)
        begin
            return 1;
        end
        if (c == ieval_pkg::OPC_MUL || c == ieval_pkg::OPC_DIV)
        begin
            return 2;
        end
        return 0;
    endfunction

    function automatic void raise_err(logic [1:0] e);
        if (err == ieval_pkg::ST_OK)
        begin
            err = e;
        end
    endfunction

    function automatic void clear_expr();
        n_opnd = 0;
        n_oper = 0;
        acc = '0;
        in_num = 0;
        have_val = 0;
        err = ieval_pkg::ST_OK;
    endfunction

    function automatic void apply_top();
        logic [2:0]  op;
        logic [31:0] a, b, r, ma, mb, q;
        if (n_oper == 0 || n_opnd < 2)
        begin
            raise_err(ieval_pkg::ST_BAD);
            return;
        end
        op = oper[n_oper-1];
        n_oper--;
        b = opnd[n_opnd-1];
        a = opnd[n_opnd-2];
        if (op == ieval_pkg::OPC_ADD)
        begin
            r = a + b;
        end
        else if (op == ieval_pkg::OPC_SUB)
        begin
            r = a - b;
        end
        else if (op == ieval_pkg::OPC_MUL)
        begin
            r = a * b;
        end
        else if (op == ieval_pkg::OPC_DIV)
        begin
            if (b == 0)
            begin
                raise_err(ieval_pkg::ST_DIV0);
                return;
            end
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = (a[31] != b[31]) ? -q : q;
        end
        else
        begin
            raise_err(ieval_pkg::ST_BAD);
            return;
        end
        n_opnd--;
        opnd[n_opnd-1] = r;
    endfunction

    function automatic void flush_number();
        if (!in_num)
        begin
            return;
        end
        in_num = 0;
        if (n_opnd >= DEPTH)
        begin
            raise_err(ieval_pkg::ST_OVF);
            return;
        end
        opnd[n_opnd] = acc;
        n_opnd++;
        acc = '0;
    endfunction

    function automatic void push_oper(logic [2:0] c);
        if (n_oper >= DEPTH)
        begin
            raise_err(ieval_pkg::ST_OVF);
            return;
        end
        oper[n_oper] = c;
        n_oper++;
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic [2:0] code;
        if (c >= ieval_pkg::CH_0 && c <= ieval_pkg::CH_9)
        begin
            if (have_val && !in_num)
            begin
                raise_err(ieval_pkg::ST_BAD);
                return;
            end
            acc = acc * 10 + 32'(c - ieval_pkg::CH_0);
            in_num = 1;
            have_val = 1;
            return;
        end
        flush_number();
        if (err != ieval_pkg::ST_OK)
        begin
            return;
        end
        if (c == ieval_pkg::CH_LPAR)
        begin
            if (have_val)
            begin
                raise_err(ieval_pkg::ST_BAD);
            end
            else
            begin
                push_oper(ieval_pkg::OPC_LPAR);
            end
            return;
        end
        if (c == ieval_pkg::CH_RPAR)
        begin
            if (!have_val)
            begin
                raise_err(ieval_pkg::ST_BAD);
                return;
            end
            while (n_oper > 0 && oper[n_oper-1] != ieval_pkg::OPC_LPAR)
            begin
                apply_top();
                if (err != ieval_pkg::ST_OK)
                begin
                    return;
                end
            end
            if (n_oper == 0)
            begin
                raise_err(ieval_pkg::ST_BAD);
            end
            else
            begin
                n_oper--;
            end
            return;
        end
        if (c == ieval_pkg::CH_PLUS)
        begin
            code = ieval_pkg::OPC_ADD;
        end
        else if (c == ieval_pkg::CH_MINUS)
        begin
            code = ieval_pkg::OPC_SUB;
        end
        else if (c == ieval_pkg::CH_STAR)
        begin
            code = ieval_pkg::OPC_MUL;
        end
        else if (c == ieval_pkg::CH_SLASH)
        begin
            code = ieval_pkg::OPC_DIV;
        end
        else
        begin
            raise_err(ieval_pkg::ST_BAD);
            return;
        end
        if (!have_val)
        begin
            raise_err(ieval_pkg::ST_BAD);
            return;
        end
        while (n_oper > 0 && oper[n_oper-1] != ieval_pkg::OPC_LPAR
               && op_rank(oper[n_oper-1]) >= op_rank(code))
        begin
            apply_top();
            if (err != ieval_pkg::ST_OK)
            begin
                return;
            end
        end
        push_oper(code);
        have_val = 0;
    endfunction

    function automatic void close_expr();
        flush_number();
        if (err != ieval_pkg::ST_OK)
        begin
            return;
        end
        if (!have_val)
        begin
            raise_err(ieval_pkg::ST_BAD);
            return;
        end
        while (n_oper > 0)
        begin
            if (oper[n_oper-1] == ieval_pkg::OPC_LPAR)
            begin
                raise_err(ieval_pkg::ST_BAD);
                return;
            end
            apply_top();
            if (err != ieval_pkg::ST_OK)
            begin
                return;
            end
        end
        if (n_opnd != 1)
        begin
            raise_err(ieval_pkg::ST_BAD);
        end
    endfunction

    function automatic void eval_word(logic [7:0] c, logic lst);
        res_t r;
        if (err == ieval_pkg::ST_OK)
        begin
            take_char(c);
        end
        if (!lst)
        begin
            return;
        end
        if (err == ieval_pkg::ST_OK)
        begin
            close_expr();
        end
        r.val = (err == ieval_pkg::ST_OK) ? opnd[0] : '0;
        r.st = err;
        pending_q.push_back(r);
        clear_expr();
    endfunction

    function automatic void add_str(string s, logic chk = 0, logic [31:0] v = 0,
                                    logic [1:0] st = ieval_pkg::ST_OK);
        row_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.ch = s[i];
            w.lst = (i == s.len() - 1);
            w.chk = chk && w.lst;
            w.val = v;
            w.st = st;
            dir_q.push_back(w);
        end
    endfunction

    task automatic send(logic [7:0] c, logic lst);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= c;
        last_char <= lst;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        words_in++;
        eval_word(c, lst);
    endtask

    task automatic send_num();
        int nd;
        nd = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 2);
        for (int i = 0; i < nd; i++)
        begin
            send(ieval_pkg::CH_0 + 8'($urandom_range(0, 9)), 0);
        end
    endtask

    // well-formed expression with random content, last word marks the end
    task automatic send_expr(int terms);
        int depth;
        byte ops[4];
        ops = '{ieval_pkg::CH_PLUS, ieval_pkg::CH_MINUS, ieval_pkg::CH_STAR,
                ieval_pkg::CH_SLASH};
        depth = 0;
        for (int t = 0; t < terms; t++)
        begin
            while ($urandom_range(0, 3) == 0)
            begin
                send(ieval_pkg::CH_LPAR, 0);
                depth++;
            end
            send_num();
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                send(ieval_pkg::CH_RPAR, 0);
                depth--;
            end
            if (t != terms - 1)
            begin
                send(ops[$urandom_range(0, 3)], 0);
            end
        end
        while (depth > 0)
        begin
            send(ieval_pkg::CH_RPAR, 0);
            depth--;
        end
        send(ieval_pkg::CH_PLUS, 0);
        send(ieval_pkg::CH_0 + 8'($urandom_range(0, 9)), 1);
    endtask

    task automatic run_directed();
        add_str("0", 1, 32'd0, ieval_pkg::ST_OK);
        add_str("4294967295", 1, 32'hFFFF_FFFF, ieval_pkg::ST_OK);
        add_str("2+3*4", 1, 32'd14, ieval_pkg::ST_OK);
        add_str("(2+3)*4", 1, 32'd20, ieval_pkg::ST_OK);
        add_str("9-7/2", 1, 32'd6, ieval_pkg::ST_OK);
        add_str("5/0", 1, 32'd0, ieval_pkg::ST_DIV0);
        add_str("2147483648/4294967295", 1, 32'h8000_0000, ieval_pkg::ST_OK);
        add_str("0-7/2", 1, 32'hFFFF_FFFD, ieval_pkg::ST_OK);
        add_str("-1", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("(1", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("1)", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("2(", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("(1)2", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("3+", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("1 ", 1, 32'd0, ieval_pkg::ST_BAD);
        add_str("1*2-8/4+6", 0);
        foreach (dir_q[i])
        begin
            send(dir_q[i].ch, dir_q[i].lst);
            if (dir_q[i].chk)
            begin
                pending_q[$].val = dir_q[i].val;
                pending_q[$].st = dir_q[i].st;
            end
        end
        send(8'h00, 0);
        send(8'hFF, 1);
    endtask

    task automatic run_random();
        while (words_in < 1700)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)), 0);
                    send(8'($urandom_range(0, 255)), 1);
                end
                1:
                begin
                    // operator stack overflow by nested parens
                    repeat ($urandom_range(30, 34))
                    begin
                        send(ieval_pkg::CH_0 + 8'($urandom_range(0, 9)), 0);
                        send(ieval_pkg::CH_PLUS, 0);
                        send(ieval_pkg::CH_LPAR, 0);
                    end
                    send(ieval_pkg::CH_0 + 8'd1, 1);
                end
                default: send_expr($urandom_range(1, 8));
            endcase
        end
    endtask

    initial
    begin
        in_valid = 0;
        character = '0;
        last_char = 0;
        rst_n = 0;
        errors = 0;
        words_in = 0;
        stim_done = 0;
        clear_expr();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // sink with random stalls and one long hold-off
    initial
    begin
        out_ready = 0;
        long_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold == 0 && words_in > 300)
            begin
                out_ready <= 0;
                long_hold = 1;
                repeat (400) @(posedge clk);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(5, 50)) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word value=%h status=%0d", $time, value, status);
            end
            else
            begin
                e = pending_q.pop_front();
                st_hits[e.st]++;
                if (value !== e.val)
                begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time, e.val, value);
                end
                if (status !== e.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
            if (idle >= WDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results pending", $time,
                         pending_q.size());
                $display("tb: failure");
                $finish;
            end
            if (stim_done && pending_q.size() == 0)
            begin
                repeat (100) @(posedge clk);
                $display("%0d characters, %0d results: ok %0d div0 %0d ovf %0d bad %0d",
                         words_in, results_seen, st_hits[0], st_hits[1], st_hits[2],
                         st_hits[3]);
                if (errors == 0 && pending_q.size() == 0)
                begin
                    $display("tb: success");
                end
                else
                begin
                    $display("tb: failure");
                end
                $finish;
            end
        end
    end

endmodule

[files.f]
hw/rtl/ieval_pkg.sv
hw/rtl/ieval_div.sv
hw/rtl/infix_expression_evaluator_unit.sv
sim/tb_top.sv
